/* src/vsm_pkg.sv */
// Shared types and constants for the vector similarity measure block.
package vsm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LENGTH  = 4096;
    localparam int CNT_W       = 13;
    localparam int SUM_W       = 28;
    localparam int EN_W        = 43;
    localparam int CROSS_W     = 44;
    localparam int DIFF_W      = 45;
    localparam int VALUE_W     = 41;
    localparam int MEAS_W      = 2;

    // queue between front and back
    localparam int Q_AW    = 1;
    localparam int Q_DEPTH = 2 ** Q_AW;

    localparam logic [MEAS_W-1:0] MEAS_EUCLID  = 2'd0;
    localparam logic [MEAS_W-1:0] MEAS_NCC     = 2'd1;
    localparam logic [MEAS_W-1:0] MEAS_PEARSON = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] elem_a;
        logic signed [SAMPLE_BITS-1:0] elem_b;
        logic                          last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      degenerate;
    } t_out_item;

    // accumulator snapshot taken at the final pair
    typedef struct packed {
        logic        [MEAS_W-1:0]  measure;
        logic        [CNT_W-1:0]   pair_count;
        logic signed [SUM_W-1:0]   sum_first;
        logic signed [SUM_W-1:0]   sum_second;
        logic        [EN_W-1:0]    energy_first;
        logic        [EN_W-1:0]    energy_second;
        logic signed [CROSS_W-1:0] cross_sum;
        logic        [DIFF_W-1:0]  diff_energy;
    } t_snap;

endpackage

/* src/vsm_front.sv */
// Front end: accepts sample pairs and accumulates the vector statistics.
module vsm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  vsm_pkg::t_in_item    i_in_data,
    input  logic [1:0]           i_measure,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output vsm_pkg::t_snap       o_q_data
);
    import vsm_pkg::*;

    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [SUM_W-1:0]   r_sa, n_sa, r_sb, n_sb;
    logic [EN_W-1:0]           r_ea, n_ea, r_eb, n_eb;
    logic signed [CROSS_W-1:0] r_sab, n_sab;
    logic [DIFF_W-1:0]         r_ed, n_ed;

    logic                      w_accept;
    logic signed [16:0]        w_diff;
    logic signed [31:0]        w_aa, w_bb, w_ab;
    logic signed [33:0]        w_dd;

    assign w_accept   = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    // per-beat products
    assign w_diff = {i_in_data.elem_a[15], i_in_data.elem_a}
                  - {i_in_data.elem_b[15], i_in_data.elem_b};
    assign w_aa   = i_in_data.elem_a * i_in_data.elem_a;
    assign w_bb   = i_in_data.elem_b * i_in_data.elem_b;
    assign w_ab   = i_in_data.elem_a * i_in_data.elem_b;
    assign w_dd   = w_diff * w_diff;

    // accumulate while below the length limit
    always_comb begin
        n_count = r_count;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_sab   = r_sab;
        n_ed    = r_ed;
        if (r_count < CNT_W'(MAX_LENGTH)) begin
            n_count = r_count + 1'b1;
            n_sa    = r_sa + SUM_W'(i_in_data.elem_a);
            n_sb    = r_sb + SUM_W'(i_in_data.elem_b);
            n_ea    = r_ea + EN_W'($unsigned(w_aa));
            n_eb    = r_eb + EN_W'($unsigned(w_bb));
            n_sab   = r_sab + CROSS_W'(w_ab);
            n_ed    = r_ed + DIFF_W'($unsigned(w_dd));
        end
    end

    // snapshot to the queue on the final pair
    assign o_q_push               = w_accept && i_in_data.last;
    assign o_q_data.measure       = i_measure;
    assign o_q_data.pair_count    = n_count;
    assign o_q_data.sum_first     = n_sa;
    assign o_q_data.sum_second    = n_sb;
    assign o_q_data.energy_first  = n_ea;
    assign o_q_data.energy_second = n_eb;
    assign o_q_data.cross_sum     = n_sab;
    assign o_q_data.diff_energy   = n_ed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_in_data.last)) begin
            r_count <= '0;
            r_sa    <= '0;
            r_sb    <= '0;
            r_ea    <= '0;
            r_eb    <= '0;
            r_sab   <= '0;
            r_ed    <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
            r_sa    <= n_sa;
            r_sb    <= n_sb;
            r_ea    <= n_ea;
            r_eb    <= n_eb;
            r_sab   <= n_sab;
            r_ed    <= n_ed;
        end
    end

endmodule

/* src/vsm_fifo.sv */
// Short queue of accumulator snapshots between front and back.
module vsm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vsm_pkg::t_snap  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output vsm_pkg::t_snap  o_data
);
    import vsm_pkg::*;

    t_snap             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr, r_rptr;
    logic [Q_AW:0]     r_fill;

    assign o_full  = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

/* src/vsm_back.sv */
// Back end: serial multiply, square root and divide sequencer per vector.
module vsm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  vsm_pkg::t_snap     i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vsm_pkg::t_out_item o_out_data
);
    import vsm_pkg::*;

    localparam int OP_W   = 56;
    localparam int ACC_W  = 2 * OP_W;
    localparam int REM_W  = 58;
    localparam int QUO_W  = 18;
    localparam int DVD_W  = 74;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_SETUP  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_STORE  = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_SQRT   = 4'd6;
    localparam logic [3:0] S_DIVSET = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    // product steps
    localparam logic [2:0] P_NSAB = 3'd0;
    localparam logic [2:0] P_SASB = 3'd1;
    localparam logic [2:0] P_NEA  = 3'd2;
    localparam logic [2:0] P_SASA = 3'd3;
    localparam logic [2:0] P_NEB  = 3'd4;
    localparam logic [2:0] P_SBSB = 3'd5;
    localparam logic [2:0] P_PQ   = 3'd6;

    logic [3:0]               r_state;
    logic [2:0]               r_step;
    logic [5:0]               r_cnt;
    t_snap                    r_snap;
    logic [ACC_W-1:0]         r_acc;
    logic [OP_W-1:0]          r_mc, r_mp;
    logic                     r_neg;
    logic signed [REM_W-1:0]  r_t, r_num;
    logic [OP_W-1:0]          r_p, r_q;
    logic [ACC_W-1:0]         r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [OP_W-1:0]          r_root;
    logic [QUO_W-1:0]         r_dlo, r_quo;
    logic signed [VALUE_W-1:0] r_val;
    logic                     r_degen;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [SUM_W-1:0]         w_abs_sa, w_abs_sb;
    logic [CROSS_W-1:0]       w_abs_sab;
    logic [OP_W:0]            w_mul_sum;
    logic [REM_W-1:0]         w_prod;
    logic signed [REM_W-1:0]  w_sprod, w_vdiff;
    logic [REM_W+1:0]         w_sq_t, w_sq_c;
    logic                     w_sq_ge;
    logic [OP_W-1:0]          w_root_nx;
    logic [OP_W:0]            w_rnd;
    logic [REM_W-1:0]         w_mag, w_dv_t, w_dv_d;
    logic [DVD_W-1:0]         w_dvd;
    logic                     w_dv_ge;
    logic [QUO_W-1:0]         w_quo_nx;
    logic [16:0]              w_qmag;
    logic                     w_out_free;

    // operand magnitudes; the most negative value reads correctly as unsigned
    assign w_abs_sa  = r_snap.sum_first[SUM_W-1]  ? -r_snap.sum_first  : r_snap.sum_first;
    assign w_abs_sb  = r_snap.sum_second[SUM_W-1] ? -r_snap.sum_second : r_snap.sum_second;
    assign w_abs_sab = r_snap.cross_sum[CROSS_W-1] ? -r_snap.cross_sum : r_snap.cross_sum;

    // shift-add multiplier step
    assign w_mul_sum = {1'b0, r_acc[ACC_W-1:OP_W]} + (r_mp[0] ? {1'b0, r_mc} : '0);
    assign w_prod    = r_acc[REM_W-1:0];
    assign w_sprod   = r_neg ? -$signed(w_prod) : $signed(w_prod);
    assign w_vdiff   = r_t - $signed(w_prod);

    // restoring square root step, two radicand bits per cycle
    assign w_sq_t    = {r_rem, r_rad[ACC_W-1:ACC_W-2]};
    assign w_sq_c    = {2'b00, r_root, 2'b01};
    assign w_sq_ge   = (w_sq_t >= w_sq_c);
    assign w_root_nx = {r_root[OP_W-2:0], w_sq_ge};
    assign w_rnd     = ({1'b0, w_root_nx} + 1'b1) >> 1;

    // restoring divide step
    assign w_mag     = r_num[REM_W-1] ? $unsigned(-r_num) : $unsigned(r_num);
    assign w_dvd     = DVD_W'({w_mag[OP_W-1:0], 16'h0000}) + DVD_W'(r_root[OP_W-1:1]);
    assign w_dv_t    = {r_rem[REM_W-2:0], r_dlo[QUO_W-1]};
    assign w_dv_d    = {2'b00, r_root};
    assign w_dv_ge   = (w_dv_t >= w_dv_d);
    assign w_quo_nx  = {r_quo[QUO_W-2:0], w_dv_ge};
    assign w_qmag    = (w_quo_nx > QUO_W'(65536)) ? 17'h10000 : w_quo_nx[16:0];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_snap  <= i_q_data;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_degen <= 1'b0;
                    r_val   <= '0;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    case (r_snap.measure)
                        MEAS_EUCLID: begin
                            r_rad   <= ACC_W'({r_snap.diff_energy, 34'h0});
                            r_state <= S_SQRT;
                        end
                        MEAS_NCC: begin
                            r_num   <= REM_W'(r_snap.cross_sum);
                            r_p     <= OP_W'(r_snap.energy_first);
                            r_q     <= OP_W'(r_snap.energy_second);
                            r_state <= S_CHECK;
                        end
                        MEAS_PEARSON: begin
                            r_step  <= P_NSAB;
                            r_state <= S_SETUP;
                        end
                        default: begin
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_SETUP: begin
                    r_acc <= '0;
                    r_cnt <= '0;
                    r_neg <= 1'b0;
                    case (r_step)
                        P_NSAB: begin
                            r_mc  <= OP_W'(r_snap.pair_count);
                            r_mp  <= OP_W'(w_abs_sab);
                            r_neg <= r_snap.cross_sum[CROSS_W-1];
                        end
                        P_SASB: begin
                            r_mc  <= OP_W'(w_abs_sa);
                            r_mp  <= OP_W'(w_abs_sb);
                            r_neg <= r_snap.sum_first[SUM_W-1] ^ r_snap.sum_second[SUM_W-1];
                        end
                        P_NEA: begin
                            r_mc <= OP_W'(r_snap.pair_count);
                            r_mp <= OP_W'(r_snap.energy_first);
                        end
                        P_SASA: begin
                            r_mc <= OP_W'(w_abs_sa);
                            r_mp <= OP_W'(w_abs_sa);
                        end
                        P_NEB: begin
                            r_mc <= OP_W'(r_snap.pair_count);
                            r_mp <= OP_W'(r_snap.energy_second);
                        end
                        P_SBSB: begin
                            r_mc <= OP_W'(w_abs_sb);
                            r_mp <= OP_W'(w_abs_sb);
                        end
                        default: begin
                            r_mc <= r_p;
                            r_mp <= r_q;
                        end
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= {w_mul_sum, r_acc[OP_W-1:1]};
                    r_mp  <= r_mp >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(OP_W - 1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_step  <= r_step + 1'b1;
                    r_state <= S_SETUP;
                    case (r_step)
                        P_NSAB: r_t   <= w_sprod;
                        P_SASB: r_num <= r_t - w_sprod;
                        P_NEA:  r_t   <= $signed(w_prod);
                        P_SASA: r_p   <= w_vdiff[REM_W-1] ? '0 : OP_W'(w_vdiff);
                        P_NEB:  r_t   <= $signed(w_prod);
                        P_SBSB: begin
                            r_q     <= w_vdiff[REM_W-1] ? '0 : OP_W'(w_vdiff);
                            r_state <= S_CHECK;
                        end
                        default: begin
                            r_rad   <= r_acc;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_SQRT;
                        end
                    endcase
                end
                S_CHECK: begin
                    // a zero energy or variance term forces a zero, degenerate result
                    if (r_p == '0 || r_q == '0) begin
                        r_degen <= 1'b1;
                        r_val   <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_step  <= P_PQ;
                        r_state <= S_SETUP;
                    end
                end
                S_SQRT: begin
                    r_rem  <= w_sq_ge ? REM_W'(w_sq_t - w_sq_c) : REM_W'(w_sq_t);
                    r_root <= w_root_nx;
                    r_rad  <= r_rad << 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 6'(OP_W - 1)) begin
                        if (r_snap.measure == MEAS_EUCLID) begin
                            r_val   <= (w_rnd > (OP_W+1)'(41'h0FF_FFFF_FFFF))
                                     ? VALUE_W'(41'h0FF_FFFF_FFFF) : VALUE_W'(w_rnd);
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_DIVSET;
                        end
                    end
                end
                S_DIVSET: begin
                    if (r_root == '0) begin
                        r_degen <= 1'b1;
                        r_val   <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_rem   <= REM_W'(w_dvd >> QUO_W);
                        r_dlo   <= w_dvd[QUO_W-1:0];
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_dv_ge ? (w_dv_t - w_dv_d) : w_dv_t;
                    r_dlo <= r_dlo << 1;
                    r_quo <= w_quo_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(QUO_W - 1)) begin
                        r_val   <= r_num[REM_W-1] ? -VALUE_W'(w_qmag) : VALUE_W'(w_qmag);
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && w_out_free) begin
            r_out.value      <= r_val;
            r_out.degenerate <= r_degen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/vector_similarity_measure.sv */
// Top level of the vector similarity measure block.
//
// Sample pairs enter on the input channel (i_in_valid / o_in_stall), one
// beat per cycle while not stalled; the beat carrying last closes the
// vector. Up to 4096 pairs are accumulated, further pairs are ignored
// until last. The closing beat hands a snapshot of the sums to a
// two-entry queue and the accumulators clear, so the next vector streams
// in at once. The back end takes one snapshot at a time through a
// shift-add multiplier, a restoring square root and a restoring divider,
// one bit per cycle. Short vectors are limited by the back end;
// o_in_stall rises while the queue is full. Results leave through a
// register on o_out_valid / i_out_stall, held while stalled; the back end
// can finish the next result meanwhile.
// The measure register is written over i_cfg_valid / o_cfg_ready, always
// ready, and resets to normalised cross-correlation. Reset clears the
// accumulators, the queue and the output valid.
module vector_similarity_measure (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vsm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vsm_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data
);
    import vsm_pkg::*;

    logic [MEAS_W-1:0] r_measure;
    logic              w_q_push, w_q_full, w_q_pop, w_q_empty;
    t_snap             w_q_in, w_q_out;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measure <= MEAS_NCC;
        end else if (i_cfg_valid) begin
            r_measure <= i_cfg_data;
        end
    end

    vsm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_measure  (r_measure),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    vsm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_out)
    );

    vsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_out),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
